// File: sv/abvi_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// abvi_pkg
// shared types and constants of the first-vcl idr detector
// ---------------------------------------------------------------------------
package abvi_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CODEC_SELECT       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUIRE_PARAM_SETS = 2'd1;

    typedef enum logic {
        CODEC_H264 = 1'b0,
        CODEC_H265 = 1'b1
    } codec_t;

    // h.264 nal unit types
    localparam logic [4:0] H264_SLICE_LO  = 5'd1;
    localparam logic [4:0] H264_SLICE_HI  = 5'd4;
    localparam logic [4:0] H264_IDR       = 5'd5;
    localparam logic [4:0] H264_SPS       = 5'd7;
    localparam logic [4:0] H264_PPS       = 5'd8;
    localparam logic [4:0] H264_AUX_SLICE = 5'd19;
    localparam logic [4:0] H264_EXT_SLICE = 5'd20;
    localparam logic [4:0] H264_3D_SLICE  = 5'd21;

    // h.265 nal unit types
    localparam logic [5:0] H265_IDR_W_RADL = 6'd19;
    localparam logic [5:0] H265_IDR_N_LP   = 6'd20;
    localparam logic [5:0] H265_VCL_MAX    = 6'd31;
    localparam logic [5:0] H265_VPS        = 6'd32;
    localparam logic [5:0] H265_SPS        = 6'd33;
    localparam logic [5:0] H265_PPS        = 6'd34;

    localparam logic [1:0] ZERO_RUN_MAX = 2'd2;
    localparam logic [7:0] BYTE_ZERO    = 8'h00;
    localparam logic [7:0] BYTE_ONE     = 8'h01;

    typedef struct packed {
        logic seen_vps;
        logic seen_sps;
        logic seen_pps;
    } param_seen_t;

    typedef struct packed {
        logic decides;
        logic idr;
        logic set_vps;
        logic set_sps;
        logic set_pps;
    } hdr_class_t;

    typedef struct packed {
        logic is_idr;
        logic found_vcl;
    } result_t;

endpackage

// File: sv/abvi_ifs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// abvi channel interfaces
// byte input, result output and configuration write channels
// ---------------------------------------------------------------------------
interface abvi_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface abvi_result_if;
    logic valid;
    logic ready;
    logic is_idr;
    logic found_vcl;

    modport source (output valid, output is_idr, output found_vcl, input ready);
    modport sink   (input valid, input is_idr, input found_vcl, output ready);
endinterface

interface abvi_cfg_if import abvi_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/annexb_first_vcl_idr_detector_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// annexb_first_vcl_idr_detector_core
// finds the first vcl nal of an annex b buffer and reports whether it is idr
// ---------------------------------------------------------------------------
// usage
//   byte_in carries one buffer byte per request, last_byte set on the final
//   byte. result carries at most one request per buffer: is_idr and
//   found_vcl at the first vcl nal header, or 0/0 at the last byte when no
//   vcl nal was seen. cfg writes codec_select (index 0) and
//   require_param_sets (index 1); it is always ready; the user must write it
//   only while no bytes are in flight, and nothing in the block enforces this.
//   throughput: one byte per cycle while result is not stalled, set by the
//   single input register stage feeding the result register.
//   the deciding byte passes the input register and then the result
//   register before its result appears on result.
//   reset clears the buffer state, both config registers and both stages.
//   when result stalls with a result held, bytes that give no result keep
//   flowing; a byte in the input register that would also produce a result
//   waits there, and byte_in drops ready until result is taken.
// ---------------------------------------------------------------------------
module annexb_first_vcl_idr_detector_core
    import abvi_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    abvi_byte_if.sink     byte_in,
    abvi_result_if.source result,
    abvi_cfg_if.sink      cfg
);

    codec_t  codec_reg, codec_next;
    logic    require_reg, require_next;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    logic    res_valid;
    logic    out_free;
    logic    load;
    result_t res;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        codec_next   = codec_reg;
        require_next = require_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_CODEC_SELECT:       codec_next   = codec_t'(cfg.data[0]);
                CFG_REQUIRE_PARAM_SETS: require_next = cfg.data[0];
                default:                ;
            endcase
        end
    end

    abvi_parser u_parser (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (byte_in.valid),
        .in_ready           (byte_in.ready),
        .in_byte            (byte_in.data_byte),
        .in_last            (byte_in.last_byte),
        .codec              (codec_reg),
        .require_param_sets (require_reg),
        .res_valid          (res_valid),
        .res_ready          (out_free),
        .res                (res)
    );

    assign out_free       = !out_valid_reg || result.ready;
    assign load           = res_valid && out_free;
    assign out_valid_next = load ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codec_reg     <= CODEC_H264;
            require_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            codec_reg     <= codec_next;
            require_reg   <= require_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= res;
    end

    assign result.valid     = out_valid_reg;
    assign result.is_idr    = out_reg.is_idr;
    assign result.found_vcl = out_reg.found_vcl;

`ifndef NO_ASSERTIONS
    // input backpressure only comes from a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_in.ready |-> (result.valid && !result.ready))
        else $error("byte input stalled without a held result");

    // an end-of-buffer result never claims idr
    a_no_idr_without_vcl: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.found_vcl) |-> !result.is_idr)
        else $error("is_idr set on a result without a vcl nal");

    // a result loaded while the receiver takes the old one stays valid
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> result.valid)
        else $error("loaded result not presented");
`endif

endmodule

// File: sv/abvi_classify.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// abvi_classify
// nal header classification for h.264 and h.265 with parameter set gating
// ---------------------------------------------------------------------------
module abvi_classify
    import abvi_pkg::*;
(
    input  logic [7:0]  hdr,
    input  codec_t      codec,
    input  logic        require_param_sets,
    input  param_seen_t seen,
    output hdr_class_t  cls
);

    logic [4:0] type_264;
    logic [5:0] type_265;
    logic       gate_264;
    logic       gate_265;

    assign type_264 = hdr[4:0];
    assign type_265 = hdr[6:1];
    assign gate_264 = !require_param_sets || (seen.seen_sps && seen.seen_pps);
    assign gate_265 = !require_param_sets ||
                      (seen.seen_vps && seen.seen_sps && seen.seen_pps);

    always_comb
    begin
        cls = '0;
        if (codec == CODEC_H264)
        begin
            case (type_264) inside
                H264_IDR:
                begin
                    cls.decides = 1'b1;
                    cls.idr     = gate_264;
                end
                [H264_SLICE_LO:H264_SLICE_HI], H264_AUX_SLICE, H264_EXT_SLICE,
                H264_3D_SLICE:
                    cls.decides = 1'b1;
                H264_SPS:
                    cls.set_sps = 1'b1;
                H264_PPS:
                    cls.set_pps = 1'b1;
                default:
                    cls = '0;
            endcase
        end
        else
        begin
            case (type_265) inside
                H265_IDR_W_RADL, H265_IDR_N_LP:
                begin
                    cls.decides = 1'b1;
                    cls.idr     = gate_265;
                end
                [6'd0:H265_VCL_MAX]:
                    cls.decides = 1'b1;
                H265_VPS:
                    cls.set_vps = 1'b1;
                H265_SPS:
                    cls.set_sps = 1'b1;
                H265_PPS:
                    cls.set_pps = 1'b1;
                default:
                    cls = '0;
            endcase
        end
    end

endmodule

// File: sv/abvi_parser.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// abvi_parser
// input byte register, start code tracking and per-buffer decision state
// ---------------------------------------------------------------------------
module abvi_parser
    import abvi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  codec_t     codec,
    input  logic       require_param_sets,
    output logic       res_valid,
    input  logic       res_ready,
    output result_t    res
);

    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;

    logic [1:0]  zero_run_reg, zero_run_next;
    logic        header_next_reg, header_next_next;
    param_seen_t seen_reg, seen_next;
    logic        decided_reg, decided_next;

    hdr_class_t  cls;
    logic        hdr_now;
    logic        decide_now;
    logic        emit;
    logic        advance;
    logic        accept;

    abvi_classify u_classify (
        .hdr                (s1_byte_reg),
        .codec              (codec),
        .require_param_sets (require_param_sets),
        .seen               (seen_reg),
        .cls                (cls)
    );

    assign hdr_now    = !decided_reg && header_next_reg;
    assign decide_now = hdr_now && cls.decides;
    // a last byte with no decision yet closes the buffer with a not-found result
    assign emit       = s1_valid_reg && (decide_now || (s1_last_reg && !decided_reg));
    assign advance    = s1_valid_reg && (!emit || res_ready);
    assign in_ready   = !s1_valid_reg || advance;
    assign accept     = in_valid && in_ready;

    assign res_valid     = emit;
    assign res.is_idr    = decide_now && cls.idr;
    assign res.found_vcl = decide_now;

    always_comb
    begin
        s1_valid_next    = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        zero_run_next    = zero_run_reg;
        header_next_next = header_next_reg;
        seen_next        = seen_reg;
        decided_next     = decided_reg;
        if (advance)
        begin
            if (!decided_reg)
            begin
                if (header_next_reg)
                begin
                    header_next_next  = 1'b0;
                    zero_run_next     = '0;
                    seen_next.seen_vps = seen_reg.seen_vps || cls.set_vps;
                    seen_next.seen_sps = seen_reg.seen_sps || cls.set_sps;
                    seen_next.seen_pps = seen_reg.seen_pps || cls.set_pps;
                    decided_next      = cls.decides;
                end
                else if (s1_byte_reg == BYTE_ZERO)
                begin
                    if (zero_run_reg != ZERO_RUN_MAX)
                        zero_run_next = zero_run_reg + 2'd1;
                end
                else
                begin
                    header_next_next = (s1_byte_reg == BYTE_ONE) &&
                                       (zero_run_reg == ZERO_RUN_MAX);
                    zero_run_next    = '0;
                end
            end
            if (s1_last_reg)
            begin
                zero_run_next    = '0;
                header_next_next = 1'b0;
                seen_next        = '0;
                decided_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            zero_run_reg    <= '0;
            header_next_reg <= 1'b0;
            seen_reg        <= '0;
            decided_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            zero_run_reg    <= zero_run_next;
            header_next_reg <= header_next_next;
            seen_reg        <= seen_next;
            decided_reg     <= decided_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= in_byte;
            s1_last_reg <= in_last;
        end
    end

endmodule
